@@ hdl/kalman_angle_gyro_fusion_defines.svh @@
// ----------------------------------------------------------------------------
// Kalman angle fusion: shared assertion macros
// Clocked implication checks, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_GYRO_FUSION_DEFINES_SVH
`define KALMAN_ANGLE_GYRO_FUSION_DEFINES_SVH

// same-cycle implication
`define KAGF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KAGF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kagf_pkg.sv @@
// ----------------------------------------------------------------------------
// Kalman angle fusion package
// Types, register indexes, micro-op codes and saturation helpers.
// ----------------------------------------------------------------------------
package kagf_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_GAIN   = 3'd4;

    // micro-op sequence, executed in order
    typedef enum logic [4:0] {
        OP_RATE, OP_ANG, OP_PD, OP_P00, OP_P01, OP_P11, OP_INNOV,
        OP_PCT0, OP_PCT1, OP_E, OP_T1, OP_K0, OP_K1,
        OP_P00C, OP_P01C, OP_P10C, OP_P11C, OP_ANGC, OP_BIASC, OP_RATE2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_WB, S_DIV, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic load_in;
        logic mul_en;
        logic wb_en;
        logic div_start;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } t_status;

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < MIN32) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sx(input logic signed [31:0] v);
        return 64'(v);
    endfunction

endpackage

@@ hdl/kagf_in_if.sv @@
// ----------------------------------------------------------------------------
// Kalman angle fusion input channel
// Valid/ready request carrying measured angle and gyro rate.
// ----------------------------------------------------------------------------
interface kagf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle_measured;
    logic signed [31:0] rate_measured;

    modport source (output valid, output angle_measured, output rate_measured, input ready);
    modport sink   (input valid, input angle_measured, input rate_measured, output ready);
endinterface

@@ hdl/kagf_out_if.sv @@
// ----------------------------------------------------------------------------
// Kalman angle fusion output channel
// Valid/ready request carrying the filtered estimates.
// ----------------------------------------------------------------------------
interface kagf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle_estimate;
    logic signed [31:0] rate_estimate;
    logic signed [31:0] bias_estimate;
    logic               divide_fault;

    modport source (output valid, output angle_estimate, output rate_estimate,
                    output bias_estimate, output divide_fault, input ready);
    modport sink   (input valid, input angle_estimate, input rate_estimate,
                    input bias_estimate, input divide_fault, output ready);
endinterface

@@ hdl/kalman_angle_gyro_fusion.sv @@
// One sample in work at a time: a new input is taken only once the previous
// result has been loaded into the output registers, later while a finished result
// waits on the output.
// Each gain division is a start, 32 + FRAC_BITS shift steps and done; the other 18
// steps are a multiply then a write-back, and the output load follows the last.
// Reset (synchronous, active low) restores registers, zero angle/bias, identity P.
// ----------------------------------------------------------------------------
// Kalman angle fusion top level
// Two-state angle/gyro-bias Kalman filter in signed fixed point.
// ----------------------------------------------------------------------------
module kalman_angle_gyro_fusion
    import kagf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    kagf_in_if.sink               i_in,
    kagf_out_if.source            o_out
);
    t_cmd    cmd;
    t_status status;

    kagf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    kagf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_angle_measured (i_in.angle_measured),
        .i_rate_measured  (i_in.rate_measured),
        .o_angle_estimate (o_out.angle_estimate),
        .o_rate_estimate  (o_out.rate_estimate),
        .o_bias_estimate  (o_out.bias_estimate),
        .o_divide_fault   (o_out.divide_fault)
    );
endmodule

@@ hdl/kagf_div.sv @@
// ----------------------------------------------------------------------------
// Kalman angle fusion gain divider
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// truncated toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
module kagf_div
    import kagf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic        [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo
);
    localparam int unsigned NW = 32 + FRAC_BITS;
    localparam int unsigned CW = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM_POS = NW'(64'h7FFF_FFFF);
    localparam logic [NW-1:0] LIM_NEG = NW'(64'h8000_0000);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_rem, n_rem;
    logic [NW-1:0] r_dvd, n_dvd;
    logic [32:0]   rem2;
    logic [31:0]   mag;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    // one shift-subtract step per cycle
    always_comb begin
        mag    = i_num[31] ? 32'(-i_num) : 32'(i_num);
        rem2   = {r_rem, r_dvd[NW-1]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NW);
            n_neg  = i_num[31];
            n_rem  = '0;
            n_dvd  = {mag, {FRAC_BITS{1'b0}}};
        end else if (r_busy) begin
            if (rem2 >= {1'b0, i_den}) begin
                n_rem = 32'(rem2 - {1'b0, i_den});
                n_dvd = {r_dvd[NW-2:0], 1'b1};
            end else begin
                n_rem = rem2[31:0];
                n_dvd = {r_dvd[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // signed, saturated quotient
    always_comb begin
        if (r_neg) begin
            o_quo = (r_dvd > LIM_NEG) ? 32'sh8000_0000 : -$signed(r_dvd[31:0]);
        end else begin
            o_quo = (r_dvd > LIM_POS) ? 32'sh7FFF_FFFF : $signed(r_dvd[31:0]);
        end
    end

    assign o_done = r_done;
endmodule

@@ hdl/kagf_datapath.sv @@
// ----------------------------------------------------------------------------
// Kalman angle fusion datapath
// Filter state, configuration registers, shared 32x32 multiplier with
// round/saturate write-back, gain divider and output registers.
// ----------------------------------------------------------------------------
module kagf_datapath
    import kagf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic signed [31:0]    i_angle_measured,
    input  logic signed [31:0]    i_rate_measured,
    output logic signed [31:0]    o_angle_estimate,
    output logic signed [31:0]    o_rate_estimate,
    output logic signed [31:0]    o_bias_estimate,
    output logic                  o_divide_fault
);
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam logic [16:0] DT_RST = 17'((ONE * 10 + 500) / 1000);
    localparam logic [22:0] QA_RST = 23'((ONE * 7 + 5) / 10);
    localparam logic [22:0] QG_RST = 23'((ONE * 3 + 5) / 10);
    localparam logic [22:0] R_RST  = 23'(ONE / 2);
    localparam logic [23:0] C_RST  = 24'(ONE);
    localparam logic signed [31:0] ONE32 = 32'(ONE);
    localparam logic signed [63:0] HALF  = 64'(longint'(1) << (FRAC_BITS - 1));

    // configuration
    logic        [16:0] r_dt;
    logic        [22:0] r_qa, r_qg, r_r;
    logic signed [23:0] r_c;
    // filter state
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] n_ang, n_bias, n_p00, n_p01, n_p10, n_p11;
    // per-sample scratch
    logic signed [31:0] r_z, r_g, r_rate, r_pd0, r_pd1, r_innov;
    logic signed [31:0] r_pct0, r_pct1, r_e, r_t1, r_k0, r_k1;
    logic signed [31:0] n_rate, n_pd0, n_pd1, n_innov;
    logic signed [31:0] n_pct0, n_pct1, n_e, n_t1, n_k0, n_k1;
    logic               r_fault, n_fault;
    logic signed [63:0] r_prod;
    logic signed [31:0] mul_a, mul_b, fm, dt32, c32, div_quo;
    logic               div_done;

    assign dt32 = $signed({15'b0, r_dt});
    assign c32  = 32'(r_c);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RST;
            r_qa <= QA_RST;
            r_qg <= QG_RST;
            r_r  <= R_RST;
            r_c  <= C_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_STEP_TIME:   r_dt <= i_cfg_wr_data[16:0];
                REG_ANGLE_NOISE: r_qa <= i_cfg_wr_data[22:0];
                REG_BIAS_NOISE:  r_qg <= i_cfg_wr_data[22:0];
                REG_MEAS_NOISE:  r_r  <= i_cfg_wr_data[22:0];
                REG_OBS_GAIN:    r_c  <= $signed(i_cfg_wr_data);
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_ANG:   begin mul_a = r_rate;                   mul_b = dt32;    end
            OP_P00:   begin mul_a = r_pd0;                    mul_b = dt32;    end
            OP_P01:   begin mul_a = r_pd1;                    mul_b = dt32;    end
            OP_P11:   begin mul_a = $signed({9'b0, r_qg});    mul_b = dt32;    end
            OP_INNOV: begin mul_a = c32;                      mul_b = r_ang;   end
            OP_PCT0:  begin mul_a = c32;                      mul_b = r_p00;   end
            OP_PCT1:  begin mul_a = c32;                      mul_b = r_p10;   end
            OP_E:     begin mul_a = c32;                      mul_b = r_pct0;  end
            OP_T1:    begin mul_a = c32;                      mul_b = r_p01;   end
            OP_P00C:  begin mul_a = r_k0;                     mul_b = r_pct0;  end
            OP_P01C:  begin mul_a = r_k0;                     mul_b = r_t1;    end
            OP_P10C:  begin mul_a = r_k1;                     mul_b = r_pct0;  end
            OP_P11C:  begin mul_a = r_k1;                     mul_b = r_t1;    end
            OP_ANGC:  begin mul_a = r_k0;                     mul_b = r_innov; end
            OP_BIASC: begin mul_a = r_k1;                     mul_b = r_innov; end
            default:  begin mul_a = '0;                       mul_b = '0;      end
        endcase
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= sx(mul_a) * sx(mul_b);
        end
    end

    // round half up, floor shift, saturate
    assign fm = sat32((r_prod + HALF) >>> FRAC_BITS);

    // write-back
    always_comb begin
        n_ang   = r_ang;   n_bias  = r_bias;
        n_p00   = r_p00;   n_p01   = r_p01;   n_p10 = r_p10; n_p11 = r_p11;
        n_rate  = r_rate;  n_pd0   = r_pd0;   n_pd1 = r_pd1; n_innov = r_innov;
        n_pct0  = r_pct0;  n_pct1  = r_pct1;  n_e   = r_e;   n_t1 = r_t1;
        n_k0    = r_k0;    n_k1    = r_k1;    n_fault = r_fault;
        case (i_cmd.op)
            OP_RATE, OP_RATE2: n_rate = sat32(sx(r_g) - sx(r_bias));
            OP_ANG:   n_ang  = sat32(sx(r_ang) + sx(fm));
            OP_PD: begin
                n_pd0 = sat32($signed({41'b0, r_qa}) - sx(r_p01) - sx(r_p10));
                n_pd1 = sat32(-sx(r_p11));
            end
            OP_P00:   n_p00 = sat32(sx(r_p00) + sx(fm));
            OP_P01: begin
                n_p01 = sat32(sx(r_p01) + sx(fm));
                n_p10 = sat32(sx(r_p10) + sx(fm));
            end
            OP_P11:   n_p11   = sat32(sx(r_p11) + sx(fm));
            OP_INNOV: n_innov = sat32(sx(r_z) - sx(fm));
            OP_PCT0:  n_pct0  = fm;
            OP_PCT1:  n_pct1  = fm;
            OP_E: begin
                n_e     = sat32($signed({41'b0, r_r}) + sx(fm));
                n_fault = (n_e <= 0);
            end
            OP_T1:    n_t1  = fm;
            OP_K0:    n_k0  = r_fault ? '0 : div_quo;
            OP_K1:    n_k1  = r_fault ? '0 : div_quo;
            OP_P00C:  n_p00 = sat32(sx(r_p00) - sx(fm));
            OP_P01C:  n_p01 = sat32(sx(r_p01) - sx(fm));
            OP_P10C:  n_p10 = sat32(sx(r_p10) - sx(fm));
            OP_P11C:  n_p11 = sat32(sx(r_p11) - sx(fm));
            OP_ANGC:  n_ang  = sat32(sx(r_ang) + sx(fm));
            OP_BIASC: n_bias = sat32(sx(r_bias) + sx(fm));
            default: ;
        endcase
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_p00  <= ONE32;
            r_p01  <= '0;
            r_p10  <= '0;
            r_p11  <= ONE32;
        end else if (i_cmd.wb_en) begin
            r_ang  <= n_ang;
            r_bias <= n_bias;
            r_p00  <= n_p00;
            r_p01  <= n_p01;
            r_p10  <= n_p10;
            r_p11  <= n_p11;
        end
    end

    // scratch registers and captured input
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_z <= i_angle_measured;
            r_g <= i_rate_measured;
        end
        if (i_cmd.wb_en) begin
            r_rate  <= n_rate;  r_pd0  <= n_pd0;  r_pd1 <= n_pd1;
            r_innov <= n_innov; r_pct0 <= n_pct0; r_pct1 <= n_pct1;
            r_e     <= n_e;     r_t1   <= n_t1;
            r_k0    <= n_k0;    r_k1   <= n_k1;   r_fault <= n_fault;
        end
    end

    // output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_angle_estimate <= r_ang;
            o_rate_estimate  <= r_rate;
            o_bias_estimate  <= r_bias;
            o_divide_fault   <= r_fault;
        end
    end

    kagf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ((i_cmd.op == OP_K0) ? r_pct0 : r_pct1),
        .i_den   (r_e),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_status.div_done = div_done;
endmodule

@@ hdl/kagf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Kalman angle fusion controller
// Walks the micro-op sequence: multiply, write back, or wait on the divider;
// handles the input and output handshakes.
// ----------------------------------------------------------------------------
module kagf_ctrl
    import kagf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    `include "kalman_angle_gyro_fusion_defines.svh"

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_out_valid, n_out_valid;
    logic   div_op, out_free;

    assign div_op   = (r_op == OP_K0) || (r_op == OP_K1);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_RATE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                    n_op    = OP_RATE;
                end
            end
            S_MUL: n_state = div_op ? S_DIV : S_WB;
            S_WB: begin
                if (r_op == OP_RATE2) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                    n_op    = t_op'(r_op + 5'd1);
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_MUL;
                    n_op    = t_op'(r_op + 5'd1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE:  begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_MUL:   begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.div_start = div_op;
            end
            S_WB:    o_cmd.wb_en = 1'b1;
            S_DIV:   o_cmd.wb_en = i_status.div_done;
            S_DONE:  o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

    `KAGF_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == S_MUL && r_op == OP_RATE, "accepted request did not start the sequence")
    `KAGF_ASSERT_NEXT(a_div_waits, o_cmd.div_start, r_state == S_DIV, "divider start without wait")
    `KAGF_ASSERT_NEXT(a_result_shown, o_cmd.out_load, r_out_valid && r_state == S_IDLE, "loaded result not presented")
    `KAGF_ASSERT_NOW(a_wb_no_mul, o_cmd.wb_en, !o_cmd.mul_en && !o_cmd.load_in, "write-back overlaps multiply or load")
endmodule
